[design/assert_macros.svh]
// Assertion macros, included by dq_datapath.
// ASSERT_AT checks that a property holds at every rising clock edge outside reset.
// ASSERT_NEVER checks that a condition never holds outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[design/dq_pkg.sv]
package dq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned SumW      = CntW + 1;

  typedef enum logic [1:0] {
    OpPushFront = 2'd0,
    OpPushBack  = 2'd1,
    OpPopFront  = 2'd2,
    OpPopBack   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnderflow = 2'd1,
    StOverflow  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the operation and read the neighbor slot
    logic exec;     // apply the operation and load the result
  } dq_cmd_t;

  // Ring index plus an offset of at most Depth, wrapped into the ring.
  function automatic logic [IdxW-1:0] add_wrap(input logic [IdxW-1:0] idx,
                                               input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(idx) + SumW'(off);
    if (sum >= SumW'(Depth)) begin
      sum = sum - SumW'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

  // Ring index minus one, wrapped into the ring.
  function automatic logic [IdxW-1:0] dec_wrap(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    if (idx == '0) begin
      res = IdxW'(Depth - 1);
    end else begin
      res = idx - IdxW'(1);
    end
    return res;
  endfunction

endpackage

[design/dq_ctrl.sv]
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output logic            done_o,
  output dq_pkg::dq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    done_d = cmd_o.exec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q == StExec);
  assign done_o = done_q;

endmodule

[design/dq_datapath.sv]
`include "assert_macros.svh"

module dq_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dq_pkg::dq_cmd_t       cmd_i,
  input  logic [1:0]            opcode_i,
  input  logic signed [31:0]    push_value_i,
  output logic signed [31:0]    popped_value_o,
  output logic [1:0]            status_o,
  output logic signed [31:0]    front_value_o,
  output logic signed [31:0]    back_value_o,
  output logic [4:0]            entry_count_o,
  output logic                  is_empty_o,
  output logic                  is_full_o
);

  localparam int unsigned IdxW = dq_pkg::IdxW;
  localparam int unsigned CntW = dq_pkg::CntW;
  localparam int unsigned DW   = dq_pkg::DataWidth;

  logic [DW-1:0] mem_q [dq_pkg::Depth];

  dq_pkg::op_e     op_q;
  logic [DW-1:0]   word_q;
  logic [DW-1:0]   rd_q;
  logic [IdxW-1:0] front_idx_q, front_idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [DW-1:0]   front_val_q, front_val_d;
  logic [DW-1:0]   back_val_q, back_val_d;
  logic [DW-1:0]   popped_q, popped_d;
  dq_pkg::status_e status_q, status_d;

  logic            empty, full;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] back_off;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  dq_pkg::op_e     op_in;

  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(dq_pkg::Depth));
  assign op_in = dq_pkg::op_e'(opcode_i);

  // Slot next to the end being popped; it becomes the new end word.
  assign back_off = (count_q >= CntW'(2)) ? (count_q - CntW'(2)) : '0;
  assign rd_addr  = (op_in == dq_pkg::OpPopFront)
                  ? dq_pkg::add_wrap(front_idx_q, CntW'(1))
                  : dq_pkg::add_wrap(front_idx_q, back_off);

  always_comb begin
    front_idx_d = front_idx_q;
    count_d     = count_q;
    front_val_d = front_val_q;
    back_val_d  = back_val_q;
    popped_d    = '0;
    status_d    = dq_pkg::StOk;
    wr_en       = 1'b0;
    wr_addr     = dq_pkg::add_wrap(front_idx_q, count_q);
    unique case (op_q)
      dq_pkg::OpPushFront: begin
        if (full) begin
          status_d = dq_pkg::StOverflow;
        end else begin
          front_idx_d = dq_pkg::dec_wrap(front_idx_q);
          wr_addr     = front_idx_d;
          wr_en       = cmd_i.exec;
          front_val_d = word_q;
          if (empty) begin
            back_val_d = word_q;
          end
          count_d = count_q + CntW'(1);
        end
      end
      dq_pkg::OpPushBack: begin
        if (full) begin
          status_d = dq_pkg::StOverflow;
        end else begin
          wr_en      = cmd_i.exec;
          back_val_d = word_q;
          if (empty) begin
            front_val_d = word_q;
          end
          count_d = count_q + CntW'(1);
        end
      end
      dq_pkg::OpPopFront: begin
        if (empty) begin
          status_d = dq_pkg::StUnderflow;
        end else begin
          popped_d    = front_val_q;
          front_idx_d = dq_pkg::add_wrap(front_idx_q, CntW'(1));
          count_d     = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            front_val_d = '0;
            back_val_d  = '0;
          end else begin
            front_val_d = rd_q;
          end
        end
      end
      dq_pkg::OpPopBack: begin
        if (empty) begin
          status_d = dq_pkg::StUnderflow;
        end else begin
          popped_d = back_val_q;
          count_d  = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            front_val_d = '0;
            back_val_d  = '0;
          end else begin
            back_val_d = rd_q;
          end
        end
      end
      default: begin
        status_d = dq_pkg::StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= word_q;
    end
    if (cmd_i.capture) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_in;
      word_q <= push_value_i[DW-1:0];
    end
    if (cmd_i.exec) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx_q <= '0;
      count_q     <= '0;
      front_val_q <= '0;
      back_val_q  <= '0;
    end else if (cmd_i.exec) begin
      front_idx_q <= front_idx_d;
      count_q     <= count_d;
      front_val_q <= front_val_d;
      back_val_q  <= back_val_d;
    end
  end

  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign front_value_o  = front_val_q;
  assign back_value_o   = back_val_q;
  assign entry_count_o  = count_q;
  assign is_empty_o     = empty;
  assign is_full_o      = full;

  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntW'(dq_pkg::Depth))
  `ASSERT_AT(a_empty_zero, clk_i, rst_ni,
             empty |-> (front_val_q == '0) && (back_val_q == '0))
  `ASSERT_AT(a_error_keeps, clk_i, rst_ni,
             (cmd_i.exec && (status_d != dq_pkg::StOk)) |=> $stable(count_q))

endmodule

[design/double_ended_queue.sv]
// Channel  | Direction | Ports                                   | Beat marked by
// ---------+-----------+-----------------------------------------+-------------------
// command  | in        | opcode_i, push_value_i                  | start_i && !busy_o
// result   | out       | popped_value_o, status_o, front_value_o,| done_o
//          |           | back_value_o, entry_count_o,            |
//          |           | is_empty_o, is_full_o                   |
//
// Every command is first captured, with a read of the ring slot next to the end
// being popped, and then applied; done_o goes high in the cycle after the apply.
// A new command is taken in the cycle that done_o is high, so a command is taken
// only once the last one is applied. The slot memory has a single read port.
// Reset clears the front index, the count and the cached end words; slot contents
// are only read after being written. The receiver cannot stall the result.

module double_ended_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] push_value_i,
  output logic               done_o,
  output logic signed [31:0] popped_value_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [4:0]         entry_count_o,
  output logic               is_empty_o,
  output logic               is_full_o
);

  // Command from the sequencer: capture a beat, then execute it.
  dq_pkg::dq_cmd_t cmd;

  // The controller only sequences; it never looks at the queue contents, since
  // every operation, including the failing ones, takes the same two steps.
  dq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // The datapath holds the ring, the front index and the count. It also keeps
  // the front and back words in registers, so a pop only needs one memory read
  // to find the word that takes the place of the one removed.
  dq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (opcode_i),
    .push_value_i   (push_value_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

endmodule
